/* rtl/core/hla_pkg.sv */
// ============================================================================
// hla_pkg
// Shared types, constants and the control store of the hyperperiod
// accumulator sequencer.
// ============================================================================
package hla_pkg;

    localparam int VALUE_W = 31;
    localparam int SHIFT_W = 5;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int STEP_W  = 3;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_ONE = {{(VALUE_W-1){1'b0}}, 1'b1};
    localparam logic [SHIFT_W-1:0] DIV_LAST  = SHIFT_W'(VALUE_W - 1);

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT     = 3'd0;
    localparam step_t STEP_CHECK    = 3'd1;
    localparam step_t STEP_GCD      = 3'd2;
    localparam step_t STEP_DIV_INIT = 3'd3;
    localparam step_t STEP_DIV      = 3'd4;
    localparam step_t STEP_MUL      = 3'd5;
    localparam step_t STEP_FINISH   = 3'd6;
    localparam step_t STEP_RETURN   = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_LOAD     = 3'd1,
        OP_GCD      = 3'd2,
        OP_DIV_INIT = 3'd3,
        OP_DIV      = 3'd4,
        OP_MUL      = 3'd5,
        OP_FINISH   = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_NO_INPUT = 3'd2,
        COND_TRIVIAL  = 3'd3,
        COND_GCD_BUSY = 3'd4,
        COND_DIV_BUSY = 3'd5,
        COND_OUT_BUSY = 3'd6
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_fire;
        logic trivial;
        logic gcd_busy;
        logic div_busy;
        logic out_busy;
    } status_t;

    function automatic ctrl_word_t rom_word(input step_t step);
        ctrl_word_t w;
        case (step)
            STEP_WAIT:     w = '{OP_LOAD,     COND_NO_INPUT, STEP_WAIT};
            STEP_CHECK:    w = '{OP_NOP,      COND_TRIVIAL,  STEP_FINISH};
            STEP_GCD:      w = '{OP_GCD,      COND_GCD_BUSY, STEP_GCD};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEVER,    STEP_WAIT};
            STEP_DIV:      w = '{OP_DIV,      COND_DIV_BUSY, STEP_DIV};
            STEP_MUL:      w = '{OP_MUL,      COND_NEVER,    STEP_WAIT};
            STEP_FINISH:   w = '{OP_FINISH,   COND_OUT_BUSY, STEP_FINISH};
            STEP_RETURN:   w = '{OP_NOP,      COND_ALWAYS,   STEP_WAIT};
            default:       w = '{OP_NOP,      COND_ALWAYS,   STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/hla_period_if.sv */
// ============================================================================
// hla_period_if
// Input channel: one task period and its path end mark per transfer.
// ============================================================================
interface hla_period_if;
    logic        valid;
    logic        ready;
    logic [30:0] period;
    logic        path_end;

    modport source (output valid, period, path_end, input ready);
    modport sink   (input valid, period, path_end, output ready);
endinterface

/* rtl/core/hla_result_if.sv */
// ============================================================================
// hla_result_if
// Output channel: running hyperperiod, overflow flag and path done mark.
// ============================================================================
interface hla_result_if;
    logic        valid;
    logic        ready;
    logic [30:0] hyperperiod;
    logic        overflowed;
    logic        path_done;

    modport source (output valid, hyperperiod, overflowed, path_done, input ready);
    modport sink   (input valid, hyperperiod, overflowed, path_done, output ready);
endinterface

/* rtl/core/hla_sequencer.sv */
// ============================================================================
// hla_sequencer
// Step counter over the control store with conditional jumps.
// ============================================================================
module hla_sequencer
(
    input  logic                clk,
    input  logic                rst_n,
    input  hla_pkg::status_t    status,
    output hla_pkg::ctrl_word_t ctrl
);

    hla_pkg::step_t step_reg;
    hla_pkg::step_t step_next;
    logic           taken;

    assign ctrl = hla_pkg::rom_word(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            hla_pkg::COND_NEVER:    taken = 1'b0;
            hla_pkg::COND_ALWAYS:   taken = 1'b1;
            hla_pkg::COND_NO_INPUT: taken = ~status.in_fire;
            hla_pkg::COND_TRIVIAL:  taken = status.trivial;
            hla_pkg::COND_GCD_BUSY: taken = status.gcd_busy;
            hla_pkg::COND_DIV_BUSY: taken = status.div_busy;
            hla_pkg::COND_OUT_BUSY: taken = status.out_busy;
            default:                taken = 1'b0;
        endcase
        step_next = taken ? ctrl.target : step_reg + hla_pkg::step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= hla_pkg::STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* rtl/core/hla_datapath.sv */
// ============================================================================
// hla_datapath
// Binary gcd, restoring divider, multiplier and result register, each
// step selected by the current control word.
// ============================================================================
module hla_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  hla_pkg::ctrl_word_t ctrl,
    output hla_pkg::status_t    status,
    hla_period_if.sink          periods,
    hla_result_if.source        results
);

    localparam int W = hla_pkg::VALUE_W;

    logic [W-1:0]                p_reg;
    logic                        last_reg;
    logic [W-1:0]                acc_reg, acc_next;
    logic                        ovf_reg, ovf_next;
    logic [W-1:0]                x_reg, x_next;
    logic [W-1:0]                y_reg, y_next;
    logic [hla_pkg::SHIFT_W-1:0] k_reg, k_next;
    logic [W-1:0]                q_reg, q_next;
    logic [W-1:0]                rem_reg, rem_next;
    logic [hla_pkg::SHIFT_W-1:0] cnt_reg, cnt_next;
    logic [hla_pkg::PROD_W-1:0]  prod_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [W-1:0]                out_value_reg;
    logic                        out_ovf_reg;
    logic                        out_done_reg;

    logic                        in_fire;
    logic                        is_zero;
    logic                        out_busy;
    logic [W:0]                  rem_shift;
    logic                        rem_ge;
    logic [W-1:0]                res_value;
    logic                        res_ovf;
    logic                        finish;

    assign periods.ready = (ctrl.op == hla_pkg::OP_LOAD);
    assign in_fire       = periods.valid & periods.ready;
    assign is_zero       = (p_reg == '0) | (acc_reg == '0);
    assign out_busy      = out_valid_reg & ~results.ready;
    assign finish        = (ctrl.op == hla_pkg::OP_FINISH) & ~out_busy;

    assign status.in_fire  = in_fire;
    assign status.trivial  = is_zero | ovf_reg;
    assign status.gcd_busy = (x_reg != y_reg);
    assign status.div_busy = (cnt_reg != hla_pkg::DIV_LAST);
    assign status.out_busy = out_busy;

    assign rem_shift = {rem_reg, q_reg[W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, x_reg});

    always_comb
    begin
        if (is_zero)
        begin
            res_value = '0;
            res_ovf   = ovf_reg;
        end
        else if (ovf_reg || (prod_reg[hla_pkg::PROD_W-1:W] != '0))
        begin
            res_value = hla_pkg::VALUE_MAX;
            res_ovf   = 1'b1;
        end
        else
        begin
            res_value = prod_reg[W-1:0];
            res_ovf   = 1'b0;
        end
    end

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        k_next   = k_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        case (ctrl.op)
            hla_pkg::OP_LOAD:
            begin
                x_next = periods.period;
                y_next = acc_reg;
                k_next = '0;
            end
            hla_pkg::OP_GCD:
            begin
                if (x_reg != y_reg)
                begin
                    case ({x_reg[0], y_reg[0]})
                        2'b00:
                        begin
                            x_next = x_reg >> 1;
                            y_next = y_reg >> 1;
                            k_next = k_reg + hla_pkg::SHIFT_W'(1);
                        end
                        2'b01:   x_next = x_reg >> 1;
                        2'b10:   y_next = y_reg >> 1;
                        default:
                        begin
                            if (x_reg > y_reg)
                            begin
                                x_next = (x_reg - y_reg) >> 1;
                            end
                            else
                            begin
                                y_next = (y_reg - x_reg) >> 1;
                            end
                        end
                    endcase
                end
            end
            hla_pkg::OP_DIV_INIT:
            begin
                q_next   = p_reg >> k_reg;
                rem_next = '0;
                cnt_next = '0;
            end
            hla_pkg::OP_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = W'(rem_shift - {1'b0, x_reg});
                end
                else
                begin
                    rem_next = rem_shift[W-1:0];
                end
                q_next   = {q_reg[W-2:0], rem_ge};
                cnt_next = cnt_reg + hla_pkg::SHIFT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg & ~results.ready;
        if (finish)
        begin
            out_valid_next = 1'b1;
            if (last_reg)
            begin
                acc_next = hla_pkg::VALUE_ONE;
                ovf_next = 1'b0;
            end
            else
            begin
                acc_next = res_value;
                ovf_next = res_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= hla_pkg::VALUE_ONE;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (in_fire)
        begin
            p_reg    <= periods.period;
            last_reg <= periods.path_end;
        end
        if (ctrl.op == hla_pkg::OP_MUL)
        begin
            prod_reg <= {{W{1'b0}}, q_reg} * {{W{1'b0}}, acc_reg};
        end
        if (finish)
        begin
            out_value_reg <= res_value;
            out_ovf_reg   <= res_ovf;
            out_done_reg  <= last_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.hyperperiod = out_value_reg;
    assign results.overflowed  = out_ovf_reg;
    assign results.path_done   = out_done_reg;

endmodule

/* rtl/core/hyperperiod_lcm_accumulator.sv */
// ============================================================================
// hyperperiod_lcm_accumulator
// Running least common multiple of task periods per path, with saturation
// and a sticky overflow flag, run by a microcoded sequencer.
//
//   Channel   Role    Payload
//   periods   sink    period[30:0], path_end
//   results   source  hyperperiod[30:0], overflowed, path_done
//
// A period with a zero operand or after overflow skips the gcd, divider
// and multiplier steps; otherwise it runs the binary gcd loop, the
// 31 bit-steps of the divider and the multiply.
// After reset the running multiple is 1 and the overflow flag is clear.
// A new period is taken while a finished result still waits; a stalled
// result holds the sequencer in its finish step.
// ============================================================================
module hyperperiod_lcm_accumulator
(
    input  logic         clk,
    input  logic         rst_n,
    hla_period_if.sink   periods,
    hla_result_if.source results
);

    hla_pkg::ctrl_word_t ctrl;
    hla_pkg::status_t    status;

    hla_sequencer u_sequencer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    hla_datapath u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .status  (status),
        .periods (periods),
        .results (results)
    );

endmodule
